FILE: rtl/atan2td_pkg.sv
// Shared types and constants for the tenth-degree atan2 approximation.
package atan2td_pkg;

	// Octant class decided at the front; selects how the back forms the angle.
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_LOW,
		CLS_HIGH
	} atan2td_cls_t;

	// Sign and class information that travels with each word through the back.
	typedef struct packed {
		atan2td_cls_t cls;
		logic         y_neg;
		logic         x_neg;
		logic         f_neg;
	} atan2td_flags_t;

	// Degrees-per-radian scale in tenths, and the turn constants in tenths of a degree.
	localparam int ANGLE_SCALE  = 573;
	localparam int HALF_TURN    = 1800;
	localparam int QUARTER_TURN = 900;

	// Denominator coefficient 0.28, kept as a ratio of integers.
	localparam int C28_NUM = 28;
	localparam int C28_DEN = 100;

	// Integer quotient bits of the second division; the quotient never exceeds 573.
	localparam int QUOT_BITS = 10;

	// Result width and the internal width used while forming the angle.
	localparam int ANGLE_WIDTH = 12;
	localparam int SUM_WIDTH   = 13;

endpackage

FILE: rtl/atan2td_fifo.sv
// Small first-in first-out queue in flip-flops with push/full and pop/empty sides.
module atan2td_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	// Status flags come straight from the occupancy count.
	assign full    = (cnt_q == (PW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers wrap at the depth, which is a power of two; the count stays between zero and the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage needs no reset; only entries below the count are ever read.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: rtl/atan2td_front.sv
// Front end: takes the magnitudes of y and x and sorts the vector into its class.
module atan2td_front import atan2td_pkg::*; #(
	parameter int INPUT_WIDTH = 32
) (
	input  logic [INPUT_WIDTH-1:0] y_value,
	input  logic [INPUT_WIDTH-1:0] x_value,
	output atan2td_flags_t         flags,
	output logic [INPUT_WIDTH-2:0] small_mag,
	output logic [INPUT_WIDTH-2:0] large_mag
);

	localparam int W = INPUT_WIDTH;

	logic         y_neg;
	logic         x_neg;
	logic [W-1:0] y_inv;
	logic [W-1:0] x_inv;
	logic [W-2:0] y_mag;
	logic [W-2:0] x_mag;

	// Two's complement magnitudes; the most negative code saturates to all ones.
	assign y_neg = y_value[W-1];
	assign x_neg = x_value[W-1];
	assign y_inv = (~y_value) + 1'b1;
	assign x_inv = (~x_value) + 1'b1;

	always_comb begin
		if (!y_neg) begin
			y_mag = y_value[W-2:0];
		end else if (y_inv[W-1]) begin
			y_mag = '1;
		end else begin
			y_mag = y_inv[W-2:0];
		end
		if (!x_neg) begin
			x_mag = x_value[W-2:0];
		end else if (x_inv[W-1]) begin
			x_mag = '1;
		end else begin
			x_mag = x_inv[W-2:0];
		end
	end

	// Choose the ratio direction and the sign of the approximated term.
	always_comb begin
		flags.y_neg = y_neg;
		flags.x_neg = x_neg;
		if (y_mag < x_mag) begin
			flags.cls   = CLS_LOW;
			flags.f_neg = (y_neg != x_neg) && (y_mag != '0);
			small_mag   = y_mag;
			large_mag   = x_mag;
		end else if (y_mag == '0) begin
			flags.cls   = CLS_ZERO;
			flags.f_neg = 1'b0;
			small_mag   = x_mag;
			large_mag   = y_mag;
		end else begin
			flags.cls   = CLS_HIGH;
			flags.f_neg = (y_neg != x_neg) && (x_mag != '0);
			small_mag   = x_mag;
			large_mag   = y_mag;
		end
	end

endmodule

FILE: rtl/atan2td_back.sv
// Back end: pipelined ratio divider, rational correction and final angle assembly.
module atan2td_back import atan2td_pkg::*; #(
	parameter int INPUT_WIDTH   = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  atan2td_flags_t           in_flags,
	input  logic [INPUT_WIDTH-2:0]   in_small,
	input  logic [INPUT_WIDTH-2:0]   in_large,
	output logic                     in_pop,
	output logic                     out_push,
	output logic signed [ANGLE_WIDTH-1:0] out_angle
);

	localparam int W  = INPUT_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int QW = F + 1;
	localparam int NW = F + QUOT_BITS;
	localparam int DW = F + 1;
	localparam int QB = QUOT_BITS;
	localparam logic [63:0] C28_FULL =
		((64'(C28_NUM) << F) + 64'(C28_DEN / 2)) / 64'(C28_DEN);
	localparam logic [F-1:0]  C28     = C28_FULL[F-1:0];
	localparam logic [DW-1:0] DEN_ONE = DW'(1) << F;

	// Ratio divider: one quotient bit of small * 2^F / large per stage.
	logic [W-1:0]   div_rem_s [F];
	logic [QW-1:0]  div_q_s   [F+1];
	logic [W-2:0]   div_lg_s  [F];
	atan2td_flags_t div_fl_s  [F+1];
	logic           div_vld_s [F+1];

	assign in_pop = en && in_valid;

	for (genvar k = 0; k <= F; k++) begin : g_div
		logic [W-1:0]   rem_in;
		logic [QW-1:0]  q_in;
		logic [W-2:0]   lg_in;
		atan2td_flags_t fl_in;
		logic           vld_in;
		logic           ge;

		if (k == 0) begin : g_head
			assign rem_in = {1'b0, in_small};
			assign q_in   = '0;
			assign lg_in  = in_large;
			assign fl_in  = in_flags;
			assign vld_in = in_valid;
		end else begin : g_body
			assign rem_in = div_rem_s[k-1];
			assign q_in   = div_q_s[k-1];
			assign lg_in  = div_lg_s[k-1];
			assign fl_in  = div_fl_s[k-1];
			assign vld_in = div_vld_s[k-1];
		end

		assign ge = (rem_in >= {1'b0, lg_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (en) begin
				div_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_q_s[k]  <= {q_in[QW-2:0], ge};
				div_fl_s[k] <= fl_in;
			end
		end

		if (k < F) begin : g_rem
			logic [W-1:0] diff;

			// Restoring step: subtract when the divisor fits, then bring in the next bit.
			assign diff = ge ? (rem_in - {1'b0, lg_in}) : rem_in;

			always_ff @(posedge clk) begin
				if (en) begin
					div_rem_s[k] <= {diff[W-2:0], 1'b0};
					div_lg_s[k]  <= lg_in;
				end
			end
		end
	end

	// Square of the ratio and the scaled numerator 573 * r.
	logic [QW-1:0]   r_val;
	logic [2*QW-1:0] r_sq;
	logic [QW-1:0]   mul_r2_s;
	logic [NW-1:0]   mul_num_s;
	atan2td_flags_t  mul_fl_s;
	logic            mul_vld_s;

	assign r_val = div_q_s[F];
	assign r_sq  = (2 * QW)'(r_val) * (2 * QW)'(r_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s <= 1'b0;
		end else if (en) begin
			mul_vld_s <= div_vld_s[F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_r2_s  <= r_sq[F +: QW];
			mul_num_s <= NW'(r_val) * NW'(ANGLE_SCALE);
			mul_fl_s  <= div_fl_s[F];
		end
	end

	// Denominator 1 + 0.28 * r^2 in the same fixed-point format.
	logic [2*F:0]   c28_prod;
	logic [DW-1:0]  nrm_den_s;
	logic [NW-1:0]  nrm_num_s;
	atan2td_flags_t nrm_fl_s;
	logic           nrm_vld_s;

	assign c28_prod = (2 * F + 1)'(C28) * (2 * F + 1)'(mul_r2_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_vld_s <= 1'b0;
		end else if (en) begin
			nrm_vld_s <= mul_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_den_s <= DEN_ONE + c28_prod[2*F:F];
			nrm_num_s <= mul_num_s;
			nrm_fl_s  <= mul_fl_s;
		end
	end

	// Integer quotient of numerator by denominator, one bit per stage, with remainder.
	logic [NW-1:0]  qd_rem_s [QB];
	logic [QB-1:0]  qd_q_s   [QB];
	logic [DW-1:0]  qd_den_s [QB];
	atan2td_flags_t qd_fl_s  [QB];
	logic           qd_vld_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_quo
		localparam int SH = QB - 1 - j;
		logic [NW-1:0]  rem_in;
		logic [QB-1:0]  q_in;
		logic [DW-1:0]  den_in;
		atan2td_flags_t fl_in;
		logic           vld_in;
		logic [NW-1:0]  sub;
		logic           ge;

		if (j == 0) begin : g_head
			assign rem_in = nrm_num_s;
			assign q_in   = '0;
			assign den_in = nrm_den_s;
			assign fl_in  = nrm_fl_s;
			assign vld_in = nrm_vld_s;
		end else begin : g_body
			assign rem_in = qd_rem_s[j-1];
			assign q_in   = qd_q_s[j-1];
			assign den_in = qd_den_s[j-1];
			assign fl_in  = qd_fl_s[j-1];
			assign vld_in = qd_vld_s[j-1];
		end

		assign sub = NW'(den_in) << SH;
		assign ge  = (rem_in >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qd_vld_s[j] <= 1'b0;
			end else if (en) begin
				qd_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qd_rem_s[j] <= ge ? (rem_in - sub) : rem_in;
				qd_q_s[j]   <= {q_in[QB-2:0], ge};
				qd_den_s[j] <= den_in;
				qd_fl_s[j]  <= fl_in;
			end
		end
	end

	// Final angle: truncation of the term, octant offset and half-turn correction.
	logic [NW-1:0]               fin_rem;
	logic [DW-1:0]               fin_den;
	atan2td_flags_t              fin_fl;
	logic signed [SUM_WIDTH-1:0] fin_q;
	logic                        frac_nz;
	logic signed [SUM_WIDTH-1:0] base;
	logic signed [SUM_WIDTH-1:0] adj;
	logic signed [SUM_WIDTH-1:0] angle;

	assign fin_rem = qd_rem_s[QB-1];
	assign fin_den = qd_den_s[QB-1];
	assign fin_fl  = qd_fl_s[QB-1];
	assign fin_q   = SUM_WIDTH'(qd_q_s[QB-1]);

	// The remainder is below the denominator, itself below 2^(F+1), so the fraction
	// bits are taken as nonzero when the remainder exceeds one, or is one over an exact unit.
	assign frac_nz = (fin_rem > NW'(1)) || ((fin_rem == NW'(1)) && (fin_den == DEN_ONE));

	always_comb begin
		case (fin_fl.cls)
			CLS_LOW: begin
				base = fin_fl.f_neg ? -fin_q : fin_q;
				if (!fin_fl.x_neg) begin
					adj = '0;
				end else if (fin_fl.y_neg) begin
					adj = -SUM_WIDTH'(HALF_TURN);
				end else begin
					adj = SUM_WIDTH'(HALF_TURN);
				end
			end
			CLS_HIGH: begin
				if (fin_fl.f_neg) begin
					base = SUM_WIDTH'(QUARTER_TURN) + fin_q;
				end else begin
					base = SUM_WIDTH'(QUARTER_TURN) - fin_q - SUM_WIDTH'(frac_nz);
				end
				adj = fin_fl.y_neg ? -SUM_WIDTH'(HALF_TURN) : '0;
			end
			default: begin
				base = '0;
				adj  = '0;
			end
		endcase
	end

	assign angle     = base + adj;
	assign out_angle = angle[ANGLE_WIDTH-1:0];
	assign out_push  = en && qd_vld_s[QB-1];

endmodule

FILE: rtl/atan2_tenth_degree_approx.sv
// Top level of the tenth-degree atan2 approximation: front, word queues and back.
//
// Usage: write a (y_value, x_value) word by raising push while full is low; the
// word is taken at that clock edge. Results leave in input order: while empty is
// low, angle_tenths holds the oldest angle (-1800..1800, tenths of a degree), and
// raising pop takes it at the next edge.
// Throughput is one word per cycle while the result queue has room; it is set by
// the fully pipelined back end, where the ratio divider gives one quotient bit
// per stage (FRACTION_BITS + 1 stages) and the integer divider ten more.
// A front queue decouples the input from the back; a four-entry result queue
// keeps words flowing while the receiver waits. When the result queue fills, the
// whole back pipeline holds, the front queue fills behind it and full rises.
// Reset (arst_n low) empties both queues and clears every pipeline valid bit;
// words in flight are dropped. No configuration is needed.
module atan2_tenth_degree_approx import atan2td_pkg::*; #(
	parameter int INPUT_WIDTH   = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [INPUT_WIDTH-1:0] y_value,
	input  logic signed [INPUT_WIDTH-1:0] x_value,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [ANGLE_WIDTH-1:0] angle_tenths
);

	localparam int W        = INPUT_WIDTH;
	localparam int FL_W     = $bits(atan2td_flags_t);
	localparam int MID_W    = FL_W + 2 * (W - 1);
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Front end classification feeds the front queue directly.
	atan2td_flags_t front_flags;
	logic [W-2:0]   front_small;
	logic [W-2:0]   front_large;

	atan2td_front #(
		.INPUT_WIDTH(INPUT_WIDTH)
	) u_front (
		.y_value  (y_value),
		.x_value  (x_value),
		.flags    (front_flags),
		.small_mag(front_small),
		.large_mag(front_large)
	);

	logic [MID_W-1:0] mid_rdata;
	logic             mid_empty;
	logic             mid_pop;

	atan2td_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({front_flags, front_small, front_large}),
		.full  (full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	// The back pipeline advances only while the result queue has room.
	logic                          out_full;
	logic                          back_en;
	logic                          back_push;
	logic signed [ANGLE_WIDTH-1:0] back_angle;
	atan2td_flags_t                mid_flags;

	assign back_en   = !out_full;
	assign mid_flags = atan2td_flags_t'(mid_rdata[MID_W-1 -: FL_W]);

	atan2td_back #(
		.INPUT_WIDTH  (INPUT_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (back_en),
		.in_valid (!mid_empty),
		.in_flags (mid_flags),
		.in_small (mid_rdata[2*(W-1)-1 -: (W-1)]),
		.in_large (mid_rdata[W-2:0]),
		.in_pop   (mid_pop),
		.out_push (back_push),
		.out_angle(back_angle)
	);

	// Result queue toward the receiver.
	atan2td_fifo #(
		.WIDTH(ANGLE_WIDTH),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (back_push),
		.wdata (back_angle),
		.full  (out_full),
		.pop   (pop),
		.rdata (angle_tenths),
		.empty (empty)
	);

`ifndef SYNTH
	// The back never hands a word to a result queue that cannot hold it.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		back_push |-> !out_full)
		else $error("back pushed a word into a full result queue");

	// The back only draws from the front queue while it holds a word.
	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back popped an empty front queue");

	// Every waiting angle lies within a half turn either way.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (angle_tenths >= -12'sd1800) && (angle_tenths <= 12'sd1800))
		else $error("angle outside -1800..1800");

	// A stalled back end neither drains the front queue nor emits a word.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_full |-> !mid_pop && !back_push)
		else $error("back moved while the result queue was full");
`endif

endmodule
